>>> rtl/core/lgst_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the lattice gradient stress tensor block
package lgst_pkg;
  localparam int unsigned SIDE_DEF       = 32;
  localparam int unsigned NUM_FIELDS_DEF = 2;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned COORD_W        = 5;
  localparam int unsigned INV_W          = 32;
  localparam int unsigned COMP_W         = 64;
  localparam int unsigned FIFO_DEPTH     = 2;
  localparam logic [INV_W-1:0] INV_RESET = 32'd65536;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [2:0]            field;
    logic [7:0]            x;
    logic [7:0]            y;
    logic [7:0]            z;
    logic [SAMPLE_W-1:0]   sample;
    logic [1:0]            row;
    logic [1:0]            col;
    logic                  bad;
  } cmd_t;
endpackage

>>> rtl/core/lattice_gradient_stress_tensor_top.sv
`timescale 1ns / 1ps
// A write item is written into the lattice memory as the lattice engine takes it. A query walks the up
// and down neighbour of each needed axis of every field through one lattice memory
// read port (two reads, a difference and an accumulate per axis; 3 axes per field
// for diagonal components, 2 for off-diagonal), then scales the sum, divides it by
// three for diagonal components and hands the result over; an invalid pair goes
// straight to the hand-over. The engine goes on while a result waits and only holds
// at the hand-over until that result is popped. Items queue in a two-entry command
// queue in front of the lattice engine. The lattice is not cleared after reset:
// query only points whose neighbours have been written.
module lattice_gradient_stress_tensor_top #(
  parameter int unsigned SIDE       = lgst_pkg::SIDE_DEF,
  parameter int unsigned NUM_FIELDS = lgst_pkg::NUM_FIELDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_op,
  input  logic                                 in_field_index,
  input  logic [4:0]                           in_pos_x,
  input  logic [4:0]                           in_pos_y,
  input  logic [4:0]                           in_pos_z,
  input  logic signed [23:0]                   in_sample,
  input  logic [1:0]                           in_row,
  input  logic [1:0]                           in_col,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [63:0]                   out_component,
  output logic                                 out_bad_pair,
  input  logic                                 cfg_we,
  input  logic [31:0]                          cfg_data
);
  logic cmd_valid, cmd_take;
  lgst_pkg::cmd_t cmd;

  lgst_front #(.SIDE(SIDE)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_op, .in_field_index,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_sample, .in_row, .in_col,
    .cmd_valid, .cmd, .cmd_take
  );

  lgst_back #(.SIDE(SIDE), .NUM_FIELDS(NUM_FIELDS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_data, .cmd_valid, .cmd, .cmd_take,
    .out_empty, .out_pop, .out_component, .out_bad_pair
  );
endmodule

>>> rtl/core/lgst_front.sv
`timescale 1ns / 1ps
// front end: takes input items, wraps coordinates, flags bad pairs, queues commands
module lgst_front #(
  parameter int unsigned SIDE = lgst_pkg::SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_op,
  input  logic                              in_field_index,
  input  logic [lgst_pkg::COORD_W-1:0]      in_pos_x,
  input  logic [lgst_pkg::COORD_W-1:0]      in_pos_y,
  input  logic [lgst_pkg::COORD_W-1:0]      in_pos_z,
  input  logic signed [lgst_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [1:0]                        in_row,
  input  logic [1:0]                        in_col,
  output logic                              cmd_valid,
  output lgst_pkg::cmd_t                    cmd,
  input  logic                              cmd_take
);
  localparam int unsigned D = lgst_pkg::FIFO_DEPTH;

  lgst_pkg::cmd_t q_r [D];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  lgst_pkg::cmd_t c;
  logic push_ok;

  function automatic logic [7:0] wrapc(input logic [lgst_pkg::COORD_W-1:0] p);
    logic [8:0] v;
    v = {4'd0, p};
    // at most ten subtractions cover any side of three or more
    for (int i = 0; i < 11; i++) begin
      if (v >= 9'(SIDE)) v = v - 9'(SIDE);
    end
    return v[7:0];
  endfunction

  always_comb begin
    c.op     = in_op;
    c.field  = {2'd0, in_field_index};
    c.x      = wrapc(in_pos_x);
    c.y      = wrapc(in_pos_y);
    c.z      = wrapc(in_pos_z);
    c.sample = in_sample;
    c.row    = in_row;
    c.col    = in_col;
    c.bad    = (in_row == 2'd0) || (in_col == 2'd0) || (in_col < in_row);
  end

  assign in_full   = (cnt_r == 2'(D));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + 1'b1;
      if (cmd_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(cmd_take);
    end
  end
endmodule

>>> rtl/core/lgst_back.sv
`timescale 1ns / 1ps
// back end: lattice memory, neighbour walk, accumulation, scaling, division by three and result register
module lgst_back #(
  parameter int unsigned SIDE       = lgst_pkg::SIDE_DEF,
  parameter int unsigned NUM_FIELDS = lgst_pkg::NUM_FIELDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lgst_pkg::INV_W-1:0]        cfg_data,
  input  logic                              cmd_valid,
  input  lgst_pkg::cmd_t                    cmd,
  output logic                              cmd_take,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [lgst_pkg::COMP_W-1:0] out_component,
  output logic                              out_bad_pair
);
  localparam int unsigned CW   = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned FW   = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int unsigned AW   = FW + 3 * CW;
  localparam int unsigned MD   = 1 << AW;
  localparam int unsigned SW   = lgst_pkg::SAMPLE_W;
  // ceil(2^35 / 3): exact quotient by three for any 34-bit dividend
  localparam logic [33:0] DIV3_M = 34'h2_AAAA_AAAB;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDA   = 8'b0000_0010,
    S_RDB   = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_SQ    = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } st_t;

  st_t st_r, st_nxt;
  logic [SW-1:0] mem [MD];
  logic [SW-1:0] rd_r;
  logic [AW-1:0] ra;
  lgst_pkg::cmd_t c_r;
  logic [FW-1:0] f_r;
  logic [1:0] ax_r;          // current axis 1..3
  logic       dn_r;          // 0 = up neighbour, 1 = down neighbour
  logic signed [SW-1:0] up_r;
  logic signed [SW:0] d_r, dprev_r;
  logic signed [2*SW+7:0] prod_r;
  logic signed [63:0] sum_r;
  logic [lgst_pkg::INV_W-1:0] inv_r;
  logic diag;
  logic [63:0] mag_r;
  logic neg_r;
  logic [95:0] wide_r;
  logic [1:0] dstep_r;
  logic [95:0] quo_r;
  logic [1:0] rem_r;
  logic mulph_r;
  logic [63:0] res_r;
  logic res_bad_r, res_v_r;
  logic res_load;

  function automatic logic [CW-1:0] up1(input logic [CW-1:0] p);
    return (p == CW'(SIDE - 1)) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [CW-1:0] dn1(input logic [CW-1:0] p);
    return (p == '0) ? CW'(SIDE - 1) : p - 1'b1;
  endfunction

  assign diag = (c_r.row == c_r.col);

  // address of the neighbour in progress
  always_comb begin
    logic [CW-1:0] x, y, z;
    x = c_r.x[CW-1:0]; y = c_r.y[CW-1:0]; z = c_r.z[CW-1:0];
    case (ax_r)
      2'd1: x = dn_r ? dn1(x) : up1(x);
      2'd2: y = dn_r ? dn1(y) : up1(y);
      default: z = dn_r ? dn1(z) : up1(z);
    endcase
    ra = {f_r, x, y, z};
  end

  logic wr_en;
  logic [AW-1:0] wa;
  assign wr_en = cmd_take && (cmd.op == lgst_pkg::OP_WRITE)
                 && ({1'b0, cmd.field} < 4'(NUM_FIELDS));
  assign wa = {cmd.field[FW-1:0], cmd.x[CW-1:0], cmd.y[CW-1:0], cmd.z[CW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wa] <= cmd.sample;
    rd_r <= mem[ra];
  end

  // axes needed: diagonal walks 1..3, off-diagonal only row and col
  logic [1:0] first_ax, next_ax;
  logic last_ax;
  always_comb begin
    first_ax = diag ? 2'd1 : c_r.row;
    last_ax  = diag ? (ax_r == 2'd3) : (ax_r == c_r.col);
    next_ax  = diag ? ax_r + 2'd1 : c_r.col;
  end

  assign cmd_take = cmd_valid && (st_r == S_IDLE);
  // the finished item moves to the result register once that is free or being popped
  assign res_load = (st_r == S_OUT) && (!res_v_r || out_pop);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (cmd_take && cmd.op == lgst_pkg::OP_QUERY)
                st_nxt = cmd.bad ? S_OUT : S_RDA;
      S_RDA:  st_nxt = S_RDB;
      S_RDB:  st_nxt = dn_r ? S_DIFF : S_RDA;
      S_DIFF: st_nxt = S_SQ;
      S_SQ: begin
        if (!last_ax) st_nxt = S_RDA;
        else if (f_r != FW'(NUM_FIELDS - 1)) st_nxt = S_RDA;
        else st_nxt = S_MUL;
      end
      S_MUL:  st_nxt = mulph_r ? (diag ? S_DIV : S_OUT) : S_MUL;
      S_DIV:  st_nxt = (dstep_r == 2'd2) ? S_OUT : S_DIV;
      S_OUT:  st_nxt = res_load ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; inv_r <= lgst_pkg::INV_RESET; res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) inv_r <= cfg_data;
      if (res_load) res_v_r <= 1'b1;
      else if (out_pop && res_v_r) res_v_r <= 1'b0;
    end
  end

  // |sum| * inv as a full 96-bit product, then shift by 18; 96-bit product keeps everything
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (cmd_take) begin
          c_r <= cmd; f_r <= '0; dn_r <= 1'b0; sum_r <= '0; mulph_r <= 1'b0;
          ax_r <= (cmd.row == cmd.col) ? 2'd1 : cmd.row;
        end
      end
      S_RDA: ;
      S_RDB: begin
        // rd_r holds the sample read from the address issued in the read cycle before
        if (!dn_r) up_r <= rd_r;
        else d_r <= $signed({up_r[SW-1], up_r}) - $signed({rd_r[SW-1], rd_r});
        dn_r <= !dn_r;
      end
      S_DIFF: begin
        if (diag) prod_r <= (2*SW+8)'(d_r * d_r);
        else if (ax_r == c_r.row) dprev_r <= d_r;
        else prod_r <= (2*SW+8)'(dprev_r * d_r);
      end
      S_SQ: begin
        if (diag) begin
          if (ax_r == c_r.row) sum_r <= sum_r + 64'(prod_r <<< 1);
          else sum_r <= sum_r - 64'(prod_r);
        end else if (ax_r == c_r.col) sum_r <= sum_r + 64'(prod_r);
        if (!last_ax) ax_r <= next_ax;
        else begin
          ax_r <= first_ax;
          f_r <= f_r + 1'b1;
        end
      end
      S_MUL: begin
        if (!mulph_r) begin
          neg_r <= sum_r[63];
          mag_r <= sum_r[63] ? 64'(-sum_r) : sum_r;
          mulph_r <= 1'b1;
          wide_r <= '0;
        end
      end
      default: ;
    endcase
    if (st_r == S_MUL && mulph_r) begin
      wide_r <= (96'(mag_r[31:0]) * 96'(inv_r) + (96'(mag_r[63:32]) * 96'(inv_r) << 32)) >> 18;
      dstep_r <= '0; rem_r <= '0;
    end
    if (st_r == S_DIV) begin
      // long division by three, one 32-bit digit a step, digit quotient by reciprocal
      logic [33:0] cur;
      logic [67:0] qp;
      logic [31:0] qd;
      logic [33:0] rm;
      cur = {rem_r, wide_r[95:64]};
      qp  = 68'(cur) * 68'(DIV3_M);
      qd  = qp[66:35];
      rm  = cur - 34'({qd, 1'b0}) - 34'(qd);
      rem_r   <= rm[1:0];
      quo_r   <= {quo_r[63:0], qd};
      wide_r  <= wide_r << 32;
      dstep_r <= dstep_r + 1'b1;
    end
    if (res_load) begin
      logic [95:0] v;
      logic [63:0] lim;
      v = diag ? quo_r : wide_r;
      lim = neg_r ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      res_bad_r <= c_r.bad;
      if (c_r.bad) res_r <= '0;
      else if (v[95:64] != '0 || v[63:0] > lim) res_r <= neg_r ? 64'(-lim) : lim;
      else res_r <= neg_r ? 64'(-v[63:0]) : v[63:0];
    end
  end

  assign out_empty     = !res_v_r;
  assign out_component = res_r;
  assign out_bad_pair  = res_bad_r;

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> st_r == S_IDLE) else $error("take outside idle");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !out_pop) |=> res_v_r) else $error("result dropped");
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && res_v_r && !out_pop) |=> st_r == S_OUT)
    else $error("result overwritten while waiting");
`endif
endmodule
